@@ src/etb_pkg.sv @@
// shared constants and types of the euler transform matrix builder
// no dependencies
package etb_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int MAX_TAB      = 24;
    localparam int TRIG_FRAC    = 30;

    // round(2^32 * pi / 180), applied with a shift of FRAC_BITS + 2
    localparam longint DEG_TO_RAD = 74961321;
    // limiting cordic gain 0.60725... in q30
    localparam longint CORDIC_GAIN = 652032874;

    localparam logic [29:0] ATAN_Q30 [MAX_TAB] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
        30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
        30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
        30'd262144,    30'd131072,    30'd65536,     30'd32768,
        30'd16384,     30'd8192,      30'd4096,      30'd2048,
        30'd1024,      30'd512,       30'd256,       30'd128
    };

    // fields that ride along with the angles
    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] scl;
        logic             inv;
    } t_side;

    // reduced angle: radians magnitude in q30 plus the sign and fold flags
    typedef struct packed {
        logic [2:0][31:0] z;
        logic [2:0]       neg;
        logic [2:0]       flip;
    } t_ang;

    // cosine and sine in q30
    typedef struct packed {
        logic [2:0][31:0] c;
        logic [2:0][31:0] s;
    } t_trig;

    // m00..m22 then t_x, t_y, t_z
    typedef logic [11:0][31:0] t_mat;

endpackage

@@ src/etb_if.sv @@
// item channels of the euler transform matrix builder
// no dependencies
interface etb_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic signed [31:0] position_z;
    logic signed [31:0] angle_x_deg;
    logic signed [31:0] angle_y_deg;
    logic signed [31:0] angle_z_deg;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
    logic               inverse_translate;

    modport source (
        output valid, position_x, position_y, position_z, angle_x_deg, angle_y_deg,
               angle_z_deg, scale_x, scale_y, scale_z, inverse_translate,
        input  ready
    );
    modport sink (
        input  valid, position_x, position_y, position_z, angle_x_deg, angle_y_deg,
               angle_z_deg, scale_x, scale_y, scale_z, inverse_translate,
        output ready
    );
endinterface

interface etb_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
    logic signed [31:0] t_x;
    logic signed [31:0] t_y;
    logic signed [31:0] t_z;

    modport source (
        output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, t_x, t_y, t_z,
        input  ready
    );
    modport sink (
        input  valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, t_x, t_y, t_z,
        output ready
    );
endinterface

@@ src/etb_angle.sv @@
// angle reduction: degrees mod 360, fold to [0,90], convert to q30 radians
// depends on etb_pkg
module etb_angle (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [2:0][31:0] i_angle,
    input  etb_pkg::t_side   i_side,
    output logic             o_valid,
    input  logic             i_ready,
    output etb_pkg::t_ang    o_ang,
    output etb_pkg::t_side   o_side
);
    import etb_pkg::*;

    localparam int     F       = FRAC_BITS;
    localparam longint FULL    = longint'(360) << F;
    localparam longint HALF    = FULL / 2;
    localparam longint QUARTER = FULL / 4;
    // angle + 2^31 is unsigned; this offset keeps the modulus unchanged
    localparam longint OFFS    = (longint'(1) << 31) % FULL;
    localparam longint ADDC    = FULL - OFFS;
    localparam int     WW      = 33 - F;
    localparam int     K       = WW + 9;
    localparam int     MW      = WW + 1;
    localparam longint RECIP   = (longint'(1) << K) / 360 + 1;
    localparam int     PW      = WW + MW;
    localparam int     QW      = PW - K;
    localparam int     RW      = F + 9;
    localparam int     MGW     = F + 7;
    localparam int     ZPW     = MGW + 27;

    logic           r_v1, r_v2, r_v3;
    logic           w_rdy1, w_rdy2, w_rdy3;
    t_side          r_side1, r_side2, r_side3;
    logic [32:0]    r_vv [3];
    logic [PW-1:0]  r_pr [3];
    logic [MGW-1:0] r_m [3];
    logic [2:0]     r_neg2, r_flip2, r_neg3, r_flip3;
    logic [31:0]    r_z [3];

    logic [32:0]    n_vv [3];
    logic [PW-1:0]  n_pr [3];
    logic [QW-1:0]  w_q [3];
    logic [32:0]    w_rr [3];
    logic [RW-1:0]  w_rem [3];
    logic [RW:0]    w_rs [3];
    logic [RW:0]    w_mag [3];
    logic [RW:0]    w_fold [3];
    logic [MGW-1:0] n_m [3];
    logic [2:0]     n_neg, n_flip;
    logic [ZPW-1:0] w_zp [3];

    assign w_rdy3  = !r_v3 || i_ready;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_vv[j] = {1'b0, ~i_angle[j][31], i_angle[j][30:0]} + 33'(ADDC);
            // quotient by 360 through a reciprocal, exact over this range
            n_pr[j] = PW'(n_vv[j][32:F]) * PW'(RECIP);

            w_q[j]   = r_pr[j][PW-1:K];
            w_rr[j]  = r_vv[j] - 33'(w_q[j]) * 33'(FULL);
            w_rem[j] = w_rr[j][RW-1:0];
            if (w_rem[j] >= RW'(HALF)) begin
                w_rs[j] = {1'b0, w_rem[j]} - (RW+1)'(FULL);
            end else begin
                w_rs[j] = {1'b0, w_rem[j]};
            end
            n_neg[j] = w_rs[j][RW];
            w_mag[j] = n_neg[j] ? (RW+1)'(-w_rs[j]) : w_rs[j];
            if (w_mag[j] > (RW+1)'(QUARTER)) begin
                w_fold[j] = (RW+1)'(HALF) - w_mag[j];
                n_flip[j] = 1'b1;
            end else begin
                w_fold[j] = w_mag[j];
                n_flip[j] = 1'b0;
            end
            n_m[j] = w_fold[j][MGW-1:0];

            w_zp[j] = ZPW'(r_m[j]) * ZPW'(DEG_TO_RAD) + (ZPW'(1) << (F + 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_side1 <= i_side;
            r_vv    <= n_vv;
            r_pr    <= n_pr;
        end
        if (w_rdy2) begin
            r_side2 <= r_side1;
            r_m     <= n_m;
            r_neg2  <= n_neg;
            r_flip2 <= n_flip;
        end
        if (w_rdy3) begin
            r_side3 <= r_side2;
            r_neg3  <= r_neg2;
            r_flip3 <= r_flip2;
            for (int j = 0; j < 3; j++) begin
                r_z[j] <= w_zp[j][F+33:F+2];
            end
        end
    end

    assign o_valid   = r_v3;
    assign o_side    = r_side3;
    assign o_ang.neg = r_neg3;
    assign o_ang.flip = r_flip3;
    assign o_ang.z[0] = r_z[0];
    assign o_ang.z[1] = r_z[1];
    assign o_ang.z[2] = r_z[2];

    // folded magnitude never passes a quarter turn
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r_m[0] <= MGW'(QUARTER) && r_m[1] <= MGW'(QUARTER)
                  && r_m[2] <= MGW'(QUARTER)))
        else $error("folded angle above quarter turn");

    // radians of a quarter turn stay below 2^31 in q30
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (!r_z[0][31] && !r_z[1][31] && !r_z[2][31]))
        else $error("reduced angle out of range");

endmodule

@@ src/etb_cordic.sv @@
// pipelined rotation-mode cordic, one stage per step, three angles side by side
// depends on etb_pkg
module etb_cordic #(
    parameter int STEPS = etb_pkg::CORDIC_STEPS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  etb_pkg::t_ang  i_ang,
    input  etb_pkg::t_side i_side,
    output logic           o_valid,
    input  logic           i_ready,
    output etb_pkg::t_trig o_trig,
    output etb_pkg::t_side o_side
);
    import etb_pkg::*;

    localparam int N = (STEPS < MAX_TAB) ? STEPS : MAX_TAB;

    logic               w_v   [N+1];
    logic               w_rdy [N+1];
    t_side              w_side [N+1];
    logic [2:0]         w_neg [N+1];
    logic [2:0]         w_flip [N+1];
    logic signed [33:0] w_x [N+1][3];
    logic signed [33:0] w_y [N+1][3];
    logic signed [33:0] w_z [N+1][3];

    logic               r_v   [N];
    t_side              r_side [N];
    logic [2:0]         r_neg [N];
    logic [2:0]         r_flip [N];
    logic signed [33:0] r_x [N][3];
    logic signed [33:0] r_y [N][3];
    logic signed [33:0] r_z [N][3];

    assign w_v[0]    = i_valid;
    assign w_side[0] = i_side;
    assign w_neg[0]  = i_ang.neg;
    assign w_flip[0] = i_ang.flip;
    assign w_rdy[N]  = i_ready;
    assign o_ready   = w_rdy[0];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_x[0][j] = 34'(CORDIC_GAIN);
            w_y[0][j] = '0;
            w_z[0][j] = $signed({2'b00, i_ang.z[j]});
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_step
        assign w_rdy[i]    = !r_v[i] || w_rdy[i+1];
        assign w_v[i+1]    = r_v[i];
        assign w_side[i+1] = r_side[i];
        assign w_neg[i+1]  = r_neg[i];
        assign w_flip[i+1] = r_flip[i];

        always_comb begin
            for (int j = 0; j < 3; j++) begin
                w_x[i+1][j] = r_x[i][j];
                w_y[i+1][j] = r_y[i][j];
                w_z[i+1][j] = r_z[i][j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i] <= 1'b0;
            end else if (w_rdy[i]) begin
                r_v[i] <= w_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[i]) begin
                r_side[i] <= w_side[i];
                r_neg[i]  <= w_neg[i];
                r_flip[i] <= w_flip[i];
                for (int j = 0; j < 3; j++) begin
                    if (!w_z[i][j][33]) begin
                        r_x[i][j] <= w_x[i][j] - (w_y[i][j] >>> i);
                        r_y[i][j] <= w_y[i][j] + (w_x[i][j] >>> i);
                        r_z[i][j] <= w_z[i][j] - $signed({4'b0000, ATAN_Q30[i]});
                    end else begin
                        r_x[i][j] <= w_x[i][j] + (w_y[i][j] >>> i);
                        r_y[i][j] <= w_y[i][j] - (w_x[i][j] >>> i);
                        r_z[i][j] <= w_z[i][j] + $signed({4'b0000, ATAN_Q30[i]});
                    end
                end
            end
        end
    end

    // restore the quadrant: fold flips cosine, negative angle flips sine
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            o_trig.c[j] = w_flip[N][j] ? 32'(-w_x[N][j]) : 32'(w_x[N][j]);
            o_trig.s[j] = w_neg[N][j]  ? 32'(-w_y[N][j]) : 32'(w_y[N][j]);
        end
    end

    assign o_valid = w_v[N];
    assign o_side  = w_side[N];

    // the rotated vector keeps unit length, so x and y stay within about one in q30
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_v[N] |-> (w_x[N][0] <= 34'sd1073807360 && w_x[N][0] >= -34'sd1073807360
                    && w_y[N][0] <= 34'sd1073807360 && w_y[N][0] >= -34'sd1073807360))
        else $error("cordic output above unit length");

endmodule

@@ src/etb_matrix.sv @@
// rotation products, row scaling, translation row and saturation
// depends on etb_pkg
module etb_matrix (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  etb_pkg::t_trig i_trig,
    input  etb_pkg::t_side i_side,
    output logic           o_valid,
    input  logic           i_ready,
    output etb_pkg::t_mat  o_mat
);
    import etb_pkg::*;

    localparam int F = FRAC_BITS;

    function automatic logic signed [33:0] mulq(input logic signed [33:0] a,
                                                input logic signed [33:0] b);
        logic signed [67:0] pr;
        pr = a * b;
        pr = pr + (68'sd1 <<< (TRIG_FRAC - 1));
        return 34'(pr >>> TRIG_FRAC);
    endfunction

    function automatic logic [31:0] sat32(input logic signed [67:0] v);
        if (v > 68'sd2147483647) begin
            return 32'h7fff_ffff;
        end else if (v < -68'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5;
    t_side r_side1, r_side2, r_side3, r_side4;

    logic signed [33:0] w_cx, w_sx, w_cy, w_sy, w_cz, w_sz;
    // sxsy cxsy cycz cxsz sxsz cysz cxcz cysx cxcy czsx
    logic signed [33:0] r_p [10];
    logic signed [33:0] r_cz, r_sz, r_sy;
    logic signed [33:0] r_rot [9];
    logic signed [33:0] n_rot [9];
    logic [31:0]        r_e3 [9];
    logic [31:0]        r_e4 [9];
    logic signed [51:0] r_tp [9];
    logic signed [67:0] w_pr3 [9];
    logic signed [67:0] w_pr4 [9];
    logic signed [32:0] w_np [3];
    logic signed [67:0] w_acc [3];
    logic [11:0][31:0]  r_out;

    assign w_rdy5  = !r_v5 || i_ready;
    assign w_rdy4  = !r_v4 || w_rdy5;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    assign w_cx = 34'($signed(i_trig.c[0]));
    assign w_sx = 34'($signed(i_trig.s[0]));
    assign w_cy = 34'($signed(i_trig.c[1]));
    assign w_sy = 34'($signed(i_trig.s[1]));
    assign w_cz = 34'($signed(i_trig.c[2]));
    assign w_sz = 34'($signed(i_trig.s[2]));

    always_comb begin
        n_rot[0] = r_p[2];
        n_rot[1] = r_p[3] + mulq(r_cz, r_p[0]);
        n_rot[2] = r_p[4] - mulq(r_cz, r_p[1]);
        n_rot[3] = -r_p[5];
        n_rot[4] = r_p[6] - mulq(r_sz, r_p[0]);
        n_rot[5] = r_p[9] + mulq(r_sz, r_p[1]);
        n_rot[6] = r_sy;
        n_rot[7] = -r_p[7];
        n_rot[8] = r_p[8];
        for (int k = 0; k < 9; k++) begin
            w_pr3[k] = r_rot[k] * $signed(r_side2.scl[k / 3]);
            w_pr3[k] = w_pr3[k] + (68'sd1 <<< (TRIG_FRAC - 1));
        end
        for (int k = 0; k < 3; k++) begin
            w_np[k] = -33'($signed(r_side3.pos[k]));
        end
        for (int k = 0; k < 9; k++) begin
            w_pr4[k] = $signed(r_e3[k]) * w_np[k / 3];
            w_pr4[k] = w_pr4[k] + (68'sd1 <<< (F - 1));
        end
        for (int j = 0; j < 3; j++) begin
            w_acc[j] = 68'(r_tp[j]) + 68'(r_tp[3 + j]) + 68'(r_tp[6 + j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
            if (w_rdy5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_side1 <= i_side;
            r_p[0]  <= mulq(w_sx, w_sy);
            r_p[1]  <= mulq(w_cx, w_sy);
            r_p[2]  <= mulq(w_cy, w_cz);
            r_p[3]  <= mulq(w_cx, w_sz);
            r_p[4]  <= mulq(w_sx, w_sz);
            r_p[5]  <= mulq(w_cy, w_sz);
            r_p[6]  <= mulq(w_cx, w_cz);
            r_p[7]  <= mulq(w_cy, w_sx);
            r_p[8]  <= mulq(w_cx, w_cy);
            r_p[9]  <= mulq(w_cz, w_sx);
            r_cz    <= w_cz;
            r_sz    <= w_sz;
            r_sy    <= w_sy;
        end
        if (w_rdy2) begin
            r_side2 <= r_side1;
            r_rot   <= n_rot;
        end
        if (w_rdy3) begin
            r_side3 <= r_side2;
            for (int k = 0; k < 9; k++) begin
                r_e3[k] <= sat32(w_pr3[k] >>> TRIG_FRAC);
            end
        end
        if (w_rdy4) begin
            r_side4 <= r_side3;
            r_e4    <= r_e3;
            for (int k = 0; k < 9; k++) begin
                r_tp[k] <= 52'(w_pr4[k] >>> F);
            end
        end
        if (w_rdy5) begin
            for (int k = 0; k < 9; k++) begin
                r_out[k] <= r_e4[k];
            end
            for (int j = 0; j < 3; j++) begin
                r_out[9 + j] <= r_side4.inv ? sat32(w_acc[j]) : r_side4.pos[j];
            end
        end
    end

    assign o_valid = r_v5;
    assign o_mat   = r_out;

    // entries of a pure rotation stay within about one in q30
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r_rot[1] <= 34'sd1073807360 && r_rot[1] >= -34'sd1073807360
                  && r_rot[5] <= 34'sd1073807360 && r_rot[5] >= -34'sd1073807360))
        else $error("rotation entry above unit range");

endmodule

@@ src/euler_transform_matrix_builder_top.sv @@
// Euler XYZ transform matrix builder. Takes one item per clock unless a
// stall holds the input: position, Euler angles in degrees and per-row
// scale, all signed Q16.16, plus the inverse-translation bit, and returns
// the scaled rotation Rx*Ry*Rz and the translation row, each saturated to
// Q16.16. The path from acceptance to result has 3 angle-reduction stages,
// one stage per cordic step and 5 matrix stages; every stage has its own
// valid bit, so items follow each other back to back and a stall on the
// output only fills the empty stages before holding the input.
// depends on etb_pkg, etb_if, etb_angle, etb_cordic, etb_matrix
module euler_transform_matrix_builder_top #(
    parameter int CORDIC_STEPS = etb_pkg::CORDIC_STEPS
) (
    input logic       i_clk,
    input logic       i_rst_n,
    etb_in_if.sink    i_in,
    etb_out_if.source o_out
);
    import etb_pkg::*;

    t_side            w_side_in, w_side_a, w_side_c;
    logic [2:0][31:0] w_angle;
    t_ang             w_ang;
    t_trig            w_trig;
    t_mat             w_mat;
    logic             w_v_a, w_rdy_a, w_v_c, w_rdy_c;

    assign w_side_in.pos = {i_in.position_z, i_in.position_y, i_in.position_x};
    assign w_side_in.scl = {i_in.scale_z, i_in.scale_y, i_in.scale_x};
    assign w_side_in.inv = i_in.inverse_translate;
    assign w_angle       = {i_in.angle_z_deg, i_in.angle_y_deg, i_in.angle_x_deg};

    etb_angle u_angle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_angle (w_angle),
        .i_side  (w_side_in),
        .o_valid (w_v_a),
        .i_ready (w_rdy_a),
        .o_ang   (w_ang),
        .o_side  (w_side_a)
    );

    etb_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v_a),
        .o_ready (w_rdy_a),
        .i_ang   (w_ang),
        .i_side  (w_side_a),
        .o_valid (w_v_c),
        .i_ready (w_rdy_c),
        .o_trig  (w_trig),
        .o_side  (w_side_c)
    );

    etb_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v_c),
        .o_ready (w_rdy_c),
        .i_trig  (w_trig),
        .i_side  (w_side_c),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_mat   (w_mat)
    );

    assign o_out.m00 = w_mat[0];
    assign o_out.m01 = w_mat[1];
    assign o_out.m02 = w_mat[2];
    assign o_out.m10 = w_mat[3];
    assign o_out.m11 = w_mat[4];
    assign o_out.m12 = w_mat[5];
    assign o_out.m20 = w_mat[6];
    assign o_out.m21 = w_mat[7];
    assign o_out.m22 = w_mat[8];
    assign o_out.t_x = w_mat[9];
    assign o_out.t_y = w_mat[10];
    assign o_out.t_z = w_mat[11];

endmodule
